### rtl/core/fwod_pkg.sv
// fwod_pkg: shared constants, codes and types of the fir window over-current detector
// no dependencies; imported by every module of the block except fwod_ram
package fwod_pkg;

    // filter geometry
    localparam int TAPS        = 32;
    localparam int SAMPLE_BITS = 12;
    localparam int COEF_BITS   = 16;
    localparam int IDX_W       = $clog2(TAPS);

    // input field width of the coefficient index
    localparam int COEF_IDX_BITS = 5;

    // arithmetic widths
    localparam int FRAC_SHIFT = 15;
    localparam int PROD_W     = SAMPLE_BITS + 1 + COEF_BITS;
    localparam int ACC_W      = PROD_W + IDX_W;
    localparam int OUT_BITS   = 19;
    localparam int OUT_MAX    = 262143;
    localparam int OUT_MIN    = -262144;

    // configuration port
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UPPER_LIMIT = 2'd0,
        REG_LOWER_LIMIT = 2'd1
    } cfg_reg_t;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;  // start of a new sum
        logic vld;    // memory read data valid this cycle
        logic last;   // this is the final tap
    } mac_ctl_t;

endpackage

### rtl/core/fwod_ram.sv
// fwod_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module fwod_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/fwod_mac.sv
// fwod_mac: registered multiply followed by an accumulator, one tap per cycle
// depends on fwod_pkg
module fwod_mac
    import fwod_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mac_ctl_t                     ctl,
    input  logic [SAMPLE_BITS-1:0]       smp,
    input  logic signed [COEF_BITS-1:0]  coef,
    output logic signed [ACC_W-1:0]      acc,
    output logic                         done
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;

    assign acc_next = acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg      <= '0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            prod_reg      <= $signed({1'b0, smp}) * coef;
            prod_vld_reg  <= ctl.vld;
            prod_last_reg <= ctl.vld & ctl.last;
            if (ctl.clear)
            begin
                acc_reg  <= '0;
                done_reg <= 1'b0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_next;
                if (prod_last_reg)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

### rtl/core/fir_window_overcurrent_detector_top.sv
// fir_window_overcurrent_detector_top: fir filter over a sample ring with window comparator
// depends on fwod_pkg, fwod_ram and fwod_mac
//
// channel   direction  handshake              payload
// --------  ---------  ---------------------  ------------------------------------------
// in        to block   in_valid / in_ready    operation, sample, coef_index, coef_value
// out       from block out_valid / out_ready  filtered_value, over_current
// cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a sample request reads every ring entry and coefficient in turn before its result is loaded;
// the single shared multiply-accumulate reads one ring entry and one coefficient per cycle
// a coefficient request leaves the block idle and ready and gives no result
// reset clears the ring and coefficients through per-entry valid bits, no clearing pass
// a result waiting on out_ready holds the next sample request at the end of its sum
// configuration writes are taken every cycle
module fir_window_overcurrent_detector_top
    import fwod_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input requests
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  logic [COEF_IDX_BITS-1:0]    coef_index,
    input  logic signed [COEF_BITS-1:0] coef_value,
    // results
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [OUT_BITS-1:0]  filtered_value,
    output logic                        over_current,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic signed [OUT_BITS-1:0]  cfg_data
);

    // width of the shifted sum and of the saturation compare
    localparam int SH_W  = ACC_W - FRAC_SHIFT;
    localparam int CMP_W = ((SH_W > OUT_BITS) ? SH_W : OUT_BITS) + 1;
    localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'(OUT_MAX);
    localparam logic signed [CMP_W-1:0] SAT_LO = CMP_W'(OUT_MIN);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_WAIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            wp_reg, wp_next;       // newest sample position
    logic [IDX_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [IDX_W-1:0]            cnt_reg, cnt_next;     // tap being read
    logic [TAPS-1:0]             ring_vld_reg, ring_vld_next;
    logic [TAPS-1:0]             coef_vld_reg, coef_vld_next;
    logic                        ring_ok_reg, ring_ok_next;
    logic                        coef_ok_reg, coef_ok_next;
    logic                        iss_vld_reg, iss_vld_next;
    logic                        iss_last_reg, iss_last_next;
    logic signed [OUT_BITS-1:0]  upper_reg, upper_next;
    logic signed [OUT_BITS-1:0]  lower_reg, lower_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [OUT_BITS-1:0]  filt_reg, filt_next;
    logic                        oc_reg, oc_next;

    logic                        in_acc;
    logic                        smp_acc;
    logic                        coef_acc;
    logic                        coef_in_range;
    logic                        issue;
    logic                        slot_free;
    logic                        load_out;
    logic [IDX_W-1:0]            wp_inc;
    logic [IDX_W-1:0]            rd_first;

    logic [SAMPLE_BITS-1:0]      ring_rd_data;
    logic [COEF_BITS-1:0]        coef_rd_data;
    logic [SAMPLE_BITS-1:0]      mac_smp;
    logic signed [COEF_BITS-1:0] mac_coef;
    mac_ctl_t                    mac_ctl;
    logic signed [ACC_W-1:0]     mac_acc;
    logic                        mac_done;

    logic signed [SH_W-1:0]      sum_sh;
    logic signed [CMP_W-1:0]     sum_cmp;
    logic signed [OUT_BITS-1:0]  sum_sat;

    // handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid & in_ready;
    assign smp_acc   = in_acc & (operation == OP_SAMPLE);
    assign coef_acc  = in_acc & (operation == OP_COEF);

    // indexes beyond the tap count are dropped
    assign coef_in_range = (32'(coef_index) < 32'(TAPS));

    // ring position arithmetic, wrapping at TAPS
    assign wp_inc   = (wp_reg == IDX_W'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_first = (wp_inc == IDX_W'(TAPS - 1)) ? '0 : wp_inc + 1'b1;

    // one ring read and one coefficient read per cycle while running
    assign issue = (state_reg == S_RUN);

    fwod_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (smp_acc),
        .wr_addr (wp_inc),
        .wr_data (sample),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (ring_rd_data)
    );

    fwod_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_acc & coef_in_range),
        .wr_addr (IDX_W'(coef_index)),
        .wr_data (coef_value),
        .rd_en   (issue),
        .rd_addr (cnt_reg),
        .rd_data (coef_rd_data)
    );

    // entries never written since reset read as zero
    assign mac_smp  = ring_ok_reg ? ring_rd_data : '0;
    assign mac_coef = coef_ok_reg ? $signed(coef_rd_data) : '0;

    assign mac_ctl.clear = smp_acc;
    assign mac_ctl.vld   = iss_vld_reg;
    assign mac_ctl.last  = iss_last_reg;

    fwod_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .smp   (mac_smp),
        .coef  (mac_coef),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    // floor shift, then clamp to the output range
    assign sum_sh  = $signed(mac_acc[ACC_W-1:FRAC_SHIFT]);
    assign sum_cmp = CMP_W'(sum_sh);

    always_comb
    begin
        priority if (sum_cmp > SAT_HI)
        begin
            sum_sat = OUT_BITS'(SAT_HI);
        end
        else if (sum_cmp < SAT_LO)
        begin
            sum_sat = OUT_BITS'(SAT_LO);
        end
        else
        begin
            sum_sat = OUT_BITS'(sum_cmp);
        end
    end

    // result slot is free when empty or being emptied this cycle
    assign slot_free = ~out_valid_reg | out_ready;
    assign load_out  = (state_reg == S_WAIT) & mac_done & slot_free;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rd_ptr_next    = rd_ptr_reg;
        cnt_next       = cnt_reg;
        ring_vld_next  = ring_vld_reg;
        coef_vld_next  = coef_vld_reg;
        ring_ok_next   = ring_vld_reg[rd_ptr_reg];
        coef_ok_next   = coef_vld_reg[cnt_reg];
        iss_vld_next   = issue;
        iss_last_next  = issue & (cnt_reg == IDX_W'(TAPS - 1));
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        filt_next      = filt_reg;
        oc_next        = oc_reg;

        // register writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_UPPER_LIMIT: upper_next = cfg_data;
                REG_LOWER_LIMIT: lower_next = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (smp_acc)
                begin
                    wp_next                = wp_inc;
                    ring_vld_next[wp_inc]  = 1'b1;
                    rd_ptr_next            = rd_first;
                    cnt_next               = '0;
                    state_next             = S_RUN;
                end
                else if (coef_acc && coef_in_range)
                begin
                    coef_vld_next[IDX_W'(coef_index)] = 1'b1;
                end
            end
            S_RUN:
            begin
                rd_ptr_next = (rd_ptr_reg == IDX_W'(TAPS - 1)) ? '0 : rd_ptr_reg + 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(TAPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    filt_next      = sum_sat;
                    oc_next        = (sum_sat > upper_reg) | (sum_sat < lower_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
            ring_vld_reg  <= '0;
            coef_vld_reg  <= '0;
            ring_ok_reg   <= 1'b0;
            coef_ok_reg   <= 1'b0;
            iss_vld_reg   <= 1'b0;
            iss_last_reg  <= 1'b0;
            upper_reg     <= OUT_BITS'(OUT_MAX);
            lower_reg     <= OUT_BITS'(OUT_MIN);
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            oc_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rd_ptr_reg    <= rd_ptr_next;
            cnt_reg       <= cnt_next;
            ring_vld_reg  <= ring_vld_next;
            coef_vld_reg  <= coef_vld_next;
            ring_ok_reg   <= ring_ok_next;
            coef_ok_reg   <= coef_ok_next;
            iss_vld_reg   <= iss_vld_next;
            iss_last_reg  <= iss_last_next;
            upper_reg     <= upper_next;
            lower_reg     <= lower_next;
            out_valid_reg <= out_valid_next;
            filt_reg      <= filt_next;
            oc_reg        <= oc_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = filt_reg;
    assign over_current   = oc_reg;

endmodule

### rtl/core/fwod_checker.sv
// fwod_checker: port-level assertions for the fir window over-current detector, with bind
// depends on fwod_pkg; attached to fir_window_overcurrent_detector_top
module fwod_checker
    import fwod_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        operation,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [OUT_BITS-1:0]  filtered_value,
    input logic                        over_current
);

    logic smp_req;
    logic coef_req;

    assign smp_req  = in_valid & in_ready & (operation == OP_SAMPLE);
    assign coef_req = in_valid & in_ready & (operation == OP_COEF);

    // a sample request occupies the filter, holding in_ready low after it
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        smp_req |=> !in_ready ##1 !in_ready)
        else $error("input ready again too soon after a sample request");

    // a coefficient load keeps the block ready
    a_coef_ready: assert property (@(posedge clk) disable iff (!rst_n)
        coef_req |=> in_ready)
        else $error("coefficient request stalled the input");

    // a coefficient load never produces a result
    a_coef_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        coef_req |=> !$rose(out_valid))
        else $error("result appeared after a coefficient request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(filtered_value) && $stable(over_current))
        else $error("stalled result changed");

endmodule

bind fir_window_overcurrent_detector_top fwod_checker u_fwod_checker (.*);

### tb/tb_fir_window_overcurrent_detector_top.sv
// tb_fir_window_overcurrent_detector_top: self-checking bench for the fir window detector
// drives sample and coefficient requests plus limit writes, predicts every filtered result
// depends on fwod_pkg and fir_window_overcurrent_detector_top
module tb_fir_window_overcurrent_detector_top
    import fwod_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // register indexes past the end of the list, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // cycles to let a sum in flight finish before touching the limits
    localparam int SETTLE_CYCLES = TAPS + 8;

    // one input request, with an optional hand-typed result
    typedef struct {
        logic                        op;
        logic [SAMPLE_BITS-1:0]      smp;
        logic [COEF_IDX_BITS-1:0]    idx;
        logic signed [COEF_BITS-1:0] cval;
        bit                          typed;
        logic signed [OUT_BITS-1:0]  fv;
        logic                        oc;
    } fir_req_t;

    // one filtered result
    typedef struct {
        logic signed [OUT_BITS-1:0] fv;
        logic                       oc;
    } fir_res_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        operation;
    logic [SAMPLE_BITS-1:0]      sample;
    logic [COEF_IDX_BITS-1:0]    coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [OUT_BITS-1:0]  filtered_value;
    logic                        over_current;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic signed [OUT_BITS-1:0]  cfg_data;

    // shadow copy of the filter state
    logic [SAMPLE_BITS-1:0]      ring_model [TAPS];
    logic signed [COEF_BITS-1:0] coef_model [TAPS];
    int                          newest_pos;
    int                          upper_lim;
    int                          lower_lim;

    // filtered results still owed by the block, oldest first
    fir_res_t pending_filtered [$];
    fir_req_t directed_rows [$];
    int       mismatch_count;
    bit       gaps_on;

    fir_window_overcurrent_detector_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .sample         (sample),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_value (filtered_value),
        .over_current   (over_current),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #5ms;
        $display("tb_fir_window_overcurrent_detector_top NOT OK");
        $finish;
    end

    // advance the shadow state by one accepted request; returns 1 when a result is owed
    function automatic bit predict_request(input fir_req_t r, output fir_res_t res);
        longint acc;
        longint f;
        int     j;
        res.fv = '0;
        res.oc = 1'b0;
        // coefficient load: store the tap, no result
        if (r.op == OP_COEF)
        begin
            if (int'(r.idx) < TAPS)
                coef_model[r.idx] = r.cval;
            return 1'b0;
        end
        // new sample lands one past the previous newest
        newest_pos = (newest_pos + 1) % TAPS;
        ring_model[newest_pos] = r.smp;
        // walk from the oldest entry (just past newest) to the newest, tap 0 first
        acc = 0;
        j = newest_pos;
        for (int i = 0; i < TAPS; i++)
        begin
            j = (j + 1) % TAPS;
            acc += longint'({1'b0, ring_model[j]}) * longint'(coef_model[i]);
        end
        // arithmetic shift floors toward minus infinity, then clamp to the output range
        f = acc >>> FRAC_SHIFT;
        if (f > OUT_MAX)
            f = OUT_MAX;
        if (f < OUT_MIN)
            f = OUT_MIN;
        res.fv = f[OUT_BITS-1:0];
        // both compares apply as written, so an inverted window flags everything
        res.oc = (f > longint'(upper_lim)) || (f < longint'(lower_lim));
        if (r.typed)
        begin
            res.fv = r.fv;
            res.oc = r.oc;
        end
        return 1'b1;
    endfunction

    function automatic void add_row(input logic op, input int smp, input int idx,
                                    input int cval, input bit typed, input int fv,
                                    input logic oc);
        fir_req_t r;
        r.op    = op;
        r.smp   = smp[SAMPLE_BITS-1:0];
        r.idx   = idx[COEF_IDX_BITS-1:0];
        r.cval  = cval[COEF_BITS-1:0];
        r.typed = typed;
        r.fv    = fv[OUT_BITS-1:0];
        r.oc    = oc;
        directed_rows.push_back(r);
    endfunction

    // random request; small_coefs keeps the non-rail coefficients in a low-pass like range
    function automatic fir_req_t random_req(input bit small_coefs, input bit force_coef);
        fir_req_t r;
        int       pick;
        r.op    = (force_coef || $urandom_range(99) < 25) ? OP_COEF : OP_SAMPLE;
        r.idx   = COEF_IDX_BITS'($urandom_range(TAPS - 1));
        r.typed = 1'b0;
        r.fv    = '0;
        r.oc    = 1'b0;
        // samples favor the rails now and then
        pick = $urandom_range(99);
        if (pick < 10)
            r.smp = '0;
        else if (pick < 20)
            r.smp = '1;
        else
            r.smp = SAMPLE_BITS'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)
            r.cval = COEF_BITS'(-32768);
        else if (pick < 16)
            r.cval = COEF_BITS'(32767);
        else if (small_coefs)
            r.cval = COEF_BITS'($urandom_range(2048));
        else
            r.cval = COEF_BITS'($urandom);
        return r;
    endfunction

    // send one request on the input channel, at times with a random gap in front of it while gaps_on is set
    task automatic push_request(input fir_req_t r);
        fir_res_t res;
        int       gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(99) < 32)
        begin
            // gaps of varied length land on every point of the sum in progress
            gap = $urandom_range(40, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= r.op;
        sample     <= r.smp;
        coef_index <= r.idx;
        coef_value <= r.cval;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // request taken at this edge
        if (predict_request(r, res))
            pending_filtered.push_back(res);
    endtask

    // write one configuration register; only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[OUT_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_UPPER_LIMIT)
            upper_lim = int'(signed'(data[OUT_BITS-1:0]));
        else if (idx == REG_LOWER_LIMIT)
            lower_lim = int'(signed'(data[OUT_BITS-1:0]));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, wait for every owed result, then let a trailing load finish
    task automatic wait_settled();
        int guard;
        guard = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_filtered.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one random phase: program a full coefficient set, then mixed requests
    task automatic run_phase(input int n_items, input bit small_coefs);
        fir_req_t r;
        for (int t = 0; t < TAPS; t++)
        begin
            r = random_req(small_coefs, 1'b1);
            r.idx = COEF_IDX_BITS'(t);
            push_request(r);
        end
        for (int n = TAPS; n < n_items; n++)
            push_request(random_req(small_coefs, 1'b0));
        wait_settled();
    endtask

    // result side: random back-pressure, check each result against the oldest owed one
    initial
    begin
        fir_res_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_filtered.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: filtered_value %0d over_current %0b",
                                 filtered_value, over_current);
                end
                else
                begin
                    want = pending_filtered.pop_front();
                    if (filtered_value !== want.fv || over_current !== want.oc)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: filtered_value exp %0d got %0d, %s%0b got %0b",
                                     want.fv, filtered_value, "over_current exp ",
                                     want.oc, over_current);
                    end
                end
            end
            @(negedge clk);
            out_ready <= gaps_on ? ($urandom_range(99) >= 32) : 1'b1;
        end
    end

    // main sequence
    initial
    begin
        // every input known from time zero
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_SAMPLE;
        sample         = '0;
        coef_index     = '0;
        coef_value     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_UPPER_LIMIT;
        cfg_data       = '0;
        mismatch_count = 0;
        gaps_on        = 1'b1;

        // shadow state matches the block after reset
        for (int i = 0; i < TAPS; i++)
        begin
            ring_model[i] = '0;
            coef_model[i] = '0;
        end
        newest_pos = 0;
        upper_lim  = OUT_MAX;
        lower_lim  = OUT_MIN;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, reset limits still in place
        add_row(OP_SAMPLE, 0, 0, 0, 1'b1, 0, 1'b0);          // ring and taps zero after reset
        add_row(OP_SAMPLE, 4095, 0, 0, 1'b1, 0, 1'b0);       // full-scale sample, zero taps
        add_row(OP_COEF, 0, 31, 32767, 1'b0, 0, 1'b0);       // newest tap at max positive
        add_row(OP_COEF, 0, 0, -32768, 1'b0, 0, 1'b0);       // oldest tap at max negative
        add_row(OP_SAMPLE, 4095, 0, 0, 1'b1, 4094, 1'b0);    // 4095 * (1 - 2^-15) floors
        add_row(OP_COEF, 0, 1, 32767, 1'b0, 0, 1'b0);
        add_row(OP_COEF, 0, 30, -32768, 1'b0, 0, 1'b0);
        add_row(OP_SAMPLE, 4095, 0, 0, 1'b0, 0, 1'b0);
        add_row(OP_SAMPLE, 0, 0, 0, 1'b0, 0, 1'b0);
        add_row(OP_SAMPLE, 2730, 0, 0, 1'b0, 0, 1'b0);       // alternating bits
        add_row(OP_SAMPLE, 1365, 0, 0, 1'b0, 0, 1'b0);
        add_row(OP_COEF, 0, 31, -1, 1'b0, 0, 1'b0);          // tiny negative tap
        add_row(OP_SAMPLE, 1, 0, 0, 1'b0, 0, 1'b0);          // negative sum floors down
        add_row(OP_COEF, 0, 15, 21845, 1'b0, 0, 1'b0);
        add_row(OP_COEF, 0, 16, -21846, 1'b0, 0, 1'b0);
        add_row(OP_SAMPLE, 4095, 0, 0, 1'b0, 0, 1'b0);
        add_row(OP_SAMPLE, 4095, 0, 0, 1'b0, 0, 1'b0);
        add_row(OP_SAMPLE, 4095, 0, 0, 1'b0, 0, 1'b0);
        add_row(OP_COEF, 0, 31, 0, 1'b0, 0, 1'b0);           // clear a tap again
        add_row(OP_SAMPLE, 2048, 31, -1, 1'b0, 0, 1'b0);     // unused fields carry junk
        add_row(OP_COEF, 4095, 2, 32767, 1'b0, 0, 1'b0);     // unused sample carries junk
        add_row(OP_SAMPLE, 4095, 0, 0, 1'b0, 0, 1'b0);
        foreach (directed_rows[k])
            push_request(directed_rows[k]);
        wait_settled();

        // widest window written explicitly, spare indexes must change nothing
        write_reg(REG_UPPER_LIMIT, OUT_MAX);
        write_reg(REG_LOWER_LIMIT, OUT_MIN);
        write_reg(REG_SPARE_2, 0);
        write_reg(REG_SPARE_3, -1);
        run_phase(200, 1'b0);

        // zero-width window: anything but zero flags
        write_reg(REG_UPPER_LIMIT, 0);
        write_reg(REG_LOWER_LIMIT, 0);
        write_reg(REG_SPARE_2, OUT_MIN);
        run_phase(200, 1'b0);

        // inverted window flags every value; this stretch runs with no gaps or stalls
        gaps_on = 1'b0;
        write_reg(REG_UPPER_LIMIT, OUT_MIN);
        write_reg(REG_LOWER_LIMIT, OUT_MAX);
        run_phase(200, 1'b1);
        gaps_on = 1'b1;

        // window around the low-pass output range
        write_reg(REG_UPPER_LIMIT, int'($urandom_range(4000, 1500)));
        write_reg(REG_LOWER_LIMIT, int'($urandom_range(1500)));
        run_phase(200, 1'b1);

        // random window near zero, may come out inverted
        write_reg(REG_UPPER_LIMIT, int'($urandom_range(16000)) - 8000);
        write_reg(REG_LOWER_LIMIT, int'($urandom_range(16000)) - 8000);
        run_phase(200, 1'b0);

        if (mismatch_count == 0 && pending_filtered.size() == 0)
            $display("tb_fir_window_overcurrent_detector_top OK");
        else
            $display("tb_fir_window_overcurrent_detector_top NOT OK");
        $finish;
    end

endmodule
